// ===== rtl/c8x_pkg.sv =====
// shared types, codes and constants of the chip8 register execute block
package c8x_pkg;

   localparam int ADDR_W              = 12;
   localparam int DATA_W              = 8;
   localparam int REG_COUNT           = 16;
   localparam int REG_W               = 4;
   localparam int KIND_W              = 5;
   localparam int STACK_DEPTH_DEFAULT = 16;

   localparam logic [ADDR_W-1:0] PC_RESET = 12'h200;
   localparam logic [REG_W-1:0]  FLAG_REG = 4'hF;

   typedef enum logic [KIND_W-1:0] {
      KIND_JUMP        = 5'd0,
      KIND_SKIP_EQ_IMM = 5'd1,
      KIND_SKIP_NE_IMM = 5'd2,
      KIND_SKIP_EQ_REG = 5'd3,
      KIND_SKIP_NE_REG = 5'd4,
      KIND_CALL        = 5'd5,
      KIND_RETURN      = 5'd6,
      KIND_LOAD        = 5'd7,
      KIND_INDEX       = 5'd8,
      KIND_COPY        = 5'd9,
      KIND_ADD_CARRY   = 5'd10,
      KIND_ADD_IMM     = 5'd11,
      KIND_SUB_XY      = 5'd12,
      KIND_SUB_YX      = 5'd13,
      KIND_SHR         = 5'd14,
      KIND_SHL         = 5'd15,
      KIND_RAND        = 5'd16
   } kind_type;

   typedef struct packed {
      logic [DATA_W-1:0] result;
      logic [DATA_W-1:0] flag;
      logic              wr_x;
      logic              wr_f;
      logic              flag_wins;
   } alu_out_type;

endpackage

// ===== rtl/c8x_ram.sv =====
// generic single write, single read ram with registered read data
module c8x_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/c8x_alu.sv =====
// data register alu: result, flag and write enables for one instruction
module c8x_alu import c8x_pkg::*; (
   input  kind_type          kind,
   input  logic [DATA_W-1:0] vx,
   input  logic [DATA_W-1:0] vy,
   input  logic [DATA_W-1:0] imm,
   input  logic [DATA_W-1:0] rnd,
   output alu_out_type       alu_out
);

   logic [DATA_W:0] sum;

   assign sum = {1'b0, vx} + {1'b0, vy};

   always_comb begin
      alu_out = '0;
      case (kind)
         KIND_LOAD: begin
            alu_out.result = imm;
            alu_out.wr_x   = 1'b1;
         end
         KIND_COPY: begin
            alu_out.result = vy;
            alu_out.wr_x   = 1'b1;
         end
         KIND_ADD_CARRY: begin
            alu_out.result = sum[DATA_W-1:0];
            alu_out.flag   = DATA_W'(sum[DATA_W]);
            alu_out.wr_x   = 1'b1;
            alu_out.wr_f   = 1'b1;
         end
         KIND_ADD_IMM: begin
            alu_out.result = vx + imm;
            alu_out.wr_x   = 1'b1;
         end
         KIND_SUB_XY: begin
            alu_out.result = vx - vy;
            alu_out.flag   = DATA_W'(vx >= vy);
            alu_out.wr_x   = 1'b1;
            alu_out.wr_f   = 1'b1;
         end
         KIND_SUB_YX: begin
            alu_out.result = vy - vx;
            alu_out.flag   = DATA_W'(vy >= vx);
            alu_out.wr_x   = 1'b1;
            alu_out.wr_f   = 1'b1;
         end
         KIND_SHR: begin
            alu_out.result    = {1'b0, vy[DATA_W-1:1]};
            alu_out.flag      = DATA_W'(vy[0]);
            alu_out.wr_x      = 1'b1;
            alu_out.wr_f      = 1'b1;
            alu_out.flag_wins = 1'b1;
         end
         KIND_SHL: begin
            alu_out.result    = {vy[DATA_W-2:0], 1'b0};
            alu_out.flag      = DATA_W'(vy[DATA_W-1]);
            alu_out.wr_x      = 1'b1;
            alu_out.wr_f      = 1'b1;
            alu_out.flag_wins = 1'b1;
         end
         KIND_RAND: begin
            alu_out.result = rnd & imm;
            alu_out.wr_x   = 1'b1;
         end
         default: begin
            alu_out = '0;
         end
      endcase
   end

endmodule

// ===== rtl/chip8_register_execute.sv =====
// chip8 register execute: top level with register file, pc, index and call stack
// an accepted item is held in the input register and its result is registered in the result register
// one item per cycle while rsp_stall does not hold the result; register file and stack reads are registered
// at input-register load, with write bypass from the item executing at that edge
// reset sets pc to 0x200 and clears index, stack pointer, vf, the data register valid bits and the handshakes
module chip8_register_execute import c8x_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [KIND_W-1:0] req_kind,
   input  logic [REG_W-1:0]  req_reg_x,
   input  logic [REG_W-1:0]  req_reg_y,
   input  logic [DATA_W-1:0] req_imm_byte,
   input  logic [ADDR_W-1:0] req_imm_address,
   input  logic [DATA_W-1:0] req_jump_offset,
   input  logic [DATA_W-1:0] req_random_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [ADDR_W-1:0] rsp_next_pc,
   output logic [ADDR_W-1:0] rsp_index_value,
   output logic [DATA_W-1:0] rsp_dest_value,
   output logic [DATA_W-1:0] rsp_flag_value,
   output logic              rsp_stack_fault
);

   localparam int SP_W = $clog2(STACK_DEPTH + 1);
   localparam int SA_W = $clog2(STACK_DEPTH);

   // input register
   logic              in_valid_ff;
   kind_type          in_kind_ff;
   logic [REG_W-1:0]  in_x_ff;
   logic [REG_W-1:0]  in_y_ff;
   logic [DATA_W-1:0] in_imm_ff;
   logic [ADDR_W-1:0] in_addr_ff;
   logic [DATA_W-1:0] in_offs_ff;
   logic [DATA_W-1:0] in_rnd_ff;

   // architectural state
   logic [ADDR_W-1:0] pc_ff, pc_in;
   logic [ADDR_W-1:0] index_ff, index_in;
   logic [SP_W-1:0]   sp_ff, sp_in;
   logic [DATA_W-1:0] vf_ff, vf_in;
   logic [REG_COUNT-1:0] vld_ff;

   // read bypass for the two register file ports and the stack, valid capture for the two register file ports
   logic              rx_hit_ff, ry_hit_ff, stk_hit_ff;
   logic [DATA_W-1:0] rx_hit_data_ff, ry_hit_data_ff;
   logic [ADDR_W-1:0] stk_hit_data_ff;
   logic              rx_vld_ff, ry_vld_ff;

   // result register
   logic              rsp_valid_ff;
   logic [ADDR_W-1:0] rsp_pc_ff;
   logic [ADDR_W-1:0] rsp_index_ff;
   logic [DATA_W-1:0] rsp_dest_ff;
   logic [DATA_W-1:0] rsp_flag_ff;
   logic              rsp_fault_ff;

   logic              advance;
   logic              exec;
   logic [REG_W-1:0]  rx_addr, ry_addr;
   logic [DATA_W-1:0] rx_q, ry_q;
   logic [DATA_W-1:0] vx_port, vy_port, vx, vy;
   logic [ADDR_W-1:0] stk_q, stk_top;
   logic [SP_W-1:0]   sp_dec;
   logic [SA_W-1:0]   stk_rd_addr;
   logic              push, pop, fault;
   logic [ADDR_W-1:0] pc_next, pc_plus2, pc_plus4;
   logic              dram_we;
   logic [DATA_W-1:0] dest_next;
   alu_out_type       alu_out;

   assign advance   = ~rsp_valid_ff | ~rsp_stall;
   assign exec      = in_valid_ff & advance;
   assign req_stall = in_valid_ff & ~advance;

   // read the operands of the item that sits in the input register after this edge
   assign rx_addr = req_stall ? in_x_ff : req_reg_x;
   assign ry_addr = req_stall ? in_y_ff : req_reg_y;

   c8x_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_ram_x (
      .clock   (clock),
      .wr_en   (dram_we),
      .wr_addr (in_x_ff),
      .wr_data (alu_out.result),
      .rd_addr (rx_addr),
      .rd_data (rx_q)
   );

   c8x_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_ram_y (
      .clock   (clock),
      .wr_en   (dram_we),
      .wr_addr (in_x_ff),
      .wr_data (alu_out.result),
      .rd_addr (ry_addr),
      .rd_data (ry_q)
   );

   assign vx_port = rx_hit_ff ? rx_hit_data_ff : (rx_vld_ff ? rx_q : '0);
   assign vy_port = ry_hit_ff ? ry_hit_data_ff : (ry_vld_ff ? ry_q : '0);
   // vf lives in its own register, outside the ram
   assign vx = (in_x_ff == FLAG_REG) ? vf_ff : vx_port;
   assign vy = (in_y_ff == FLAG_REG) ? vf_ff : vy_port;

   c8x_alu u_alu (
      .kind    (in_kind_ff),
      .vx      (vx),
      .vy      (vy),
      .imm     (in_imm_ff),
      .rnd     (in_rnd_ff),
      .alu_out (alu_out)
   );

   // stack ram always reads the entry below the next stack pointer
   assign sp_dec      = sp_in - SP_W'(1);
   assign stk_rd_addr = sp_dec[SA_W-1:0];
   assign stk_top     = stk_hit_ff ? stk_hit_data_ff : stk_q;

   c8x_ram #(.WIDTH(ADDR_W), .DEPTH(STACK_DEPTH)) u_ram_stack (
      .clock   (clock),
      .wr_en   (exec & push),
      .wr_addr (sp_ff[SA_W-1:0]),
      .wr_data (pc_plus2),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_q)
   );

   assign pc_plus2 = pc_ff + ADDR_W'(2);
   assign pc_plus4 = pc_ff + ADDR_W'(4);

   always_comb begin
      pc_next  = pc_plus2;
      index_in = index_ff;
      push     = 1'b0;
      pop      = 1'b0;
      fault    = 1'b0;
      case (in_kind_ff)
         KIND_JUMP: begin
            pc_next = in_addr_ff + ADDR_W'(in_offs_ff);
         end
         KIND_SKIP_EQ_IMM: begin
            if (vx == in_imm_ff) pc_next = pc_plus4;
         end
         KIND_SKIP_NE_IMM: begin
            if (vx != in_imm_ff) pc_next = pc_plus4;
         end
         KIND_SKIP_EQ_REG: begin
            if (vx == vy) pc_next = pc_plus4;
         end
         KIND_SKIP_NE_REG: begin
            if (vx != vy) pc_next = pc_plus4;
         end
         KIND_CALL: begin
            if (sp_ff >= SP_W'(STACK_DEPTH)) begin
               fault   = 1'b1;
               pc_next = pc_ff;
            end else begin
               push    = 1'b1;
               pc_next = in_addr_ff;
            end
         end
         KIND_RETURN: begin
            if (sp_ff == '0) begin
               fault   = 1'b1;
               pc_next = pc_ff;
            end else begin
               pop     = 1'b1;
               pc_next = stk_top;
            end
         end
         KIND_INDEX: begin
            index_in = in_addr_ff;
         end
         default: begin
            pc_next = pc_plus2;
         end
      endcase
   end

   always_comb begin
      if (exec & push) begin
         sp_in = sp_ff + SP_W'(1);
      end else if (exec & pop) begin
         sp_in = sp_ff - SP_W'(1);
      end else begin
         sp_in = sp_ff;
      end
   end

   assign pc_in   = exec ? pc_next : pc_ff;
   assign dram_we = exec & alu_out.wr_x & (in_x_ff != FLAG_REG);

   // add and subtract into vf keep the result, shifts keep the flag
   always_comb begin
      if (alu_out.wr_f && (alu_out.flag_wins || in_x_ff != FLAG_REG)) begin
         vf_in = alu_out.flag;
      end else if (alu_out.wr_x && in_x_ff == FLAG_REG) begin
         vf_in = alu_out.result;
      end else begin
         vf_in = vf_ff;
      end
   end

   assign dest_next = (in_x_ff == FLAG_REG) ? vf_in : (alu_out.wr_x ? alu_out.result : vx);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= PC_RESET;
         index_ff     <= '0;
         sp_ff        <= '0;
         vf_ff        <= '0;
         vld_ff       <= '0;
         rx_hit_ff    <= 1'b0;
         ry_hit_ff    <= 1'b0;
         stk_hit_ff   <= 1'b0;
         rx_vld_ff    <= 1'b0;
         ry_vld_ff    <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
         pc_ff      <= pc_in;
         sp_ff      <= sp_in;
         stk_hit_ff <= exec & push;
         rx_hit_ff  <= dram_we && (in_x_ff == rx_addr);
         ry_hit_ff  <= dram_we && (in_x_ff == ry_addr);
         rx_vld_ff  <= vld_ff[rx_addr];
         ry_vld_ff  <= vld_ff[ry_addr];
         if (exec) begin
            index_ff <= index_in;
            vf_ff    <= vf_in;
         end
         if (dram_we) begin
            vld_ff[in_x_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_kind_ff <= kind_type'(req_kind);
         in_x_ff    <= req_reg_x;
         in_y_ff    <= req_reg_y;
         in_imm_ff  <= req_imm_byte;
         in_addr_ff <= req_imm_address;
         in_offs_ff <= req_jump_offset;
         in_rnd_ff  <= req_random_byte;
      end
      rx_hit_data_ff  <= alu_out.result;
      ry_hit_data_ff  <= alu_out.result;
      stk_hit_data_ff <= pc_plus2;
      if (exec) begin
         rsp_pc_ff    <= pc_next;
         rsp_index_ff <= index_in;
         rsp_dest_ff  <= dest_next;
         rsp_flag_ff  <= vf_in;
         rsp_fault_ff <= fault;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_next_pc     = rsp_pc_ff;
   assign rsp_index_value = rsp_index_ff;
   assign rsp_dest_value  = rsp_dest_ff;
   assign rsp_flag_value  = rsp_flag_ff;
   assign rsp_stack_fault = rsp_fault_ff;

endmodule
